>>> src/supply_voltage_band_classifier_top_defines.svh
// Assertion macros used by the checker file.
`ifndef SUPPLY_VOLTAGE_BAND_CLASSIFIER_TOP_DEFINES_SVH
`define SUPPLY_VOLTAGE_BAND_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SVBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SVBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/svbc_pkg.sv
package svbc_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int THR_W          = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int BAND_W         = 3;
    localparam int ADC_FULL_SCALE = 4096;
    localparam int LF_EXIT_LEVEL  = 1166;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE_S = SAMPLE_W'(ADC_FULL_SCALE);
    localparam logic [SAMPLE_W-1:0] LF_EXIT_S    = SAMPLE_W'(LF_EXIT_LEVEL);

    typedef enum logic [BAND_W-1:0] {
        BAND_LF   = 3'd0,
        BAND_LOW  = 3'd1,
        BAND_NORM = 3'd2,
        BAND_HIGH = 3'd3,
        BAND_HF   = 3'd4,
        BAND_INIT = 3'd5
    } t_band;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LO_FAULT      = 3'd0,
        REG_LO_FLAG_SET   = 3'd1,
        REG_NORM_RET_LOW  = 3'd2,
        REG_NORM_ENT_LOW  = 3'd3,
        REG_NORM_RET_HIGH = 3'd4,
        REG_NORM_LV_HIGH  = 3'd5,
        REG_HI_FLAG_SET   = 3'd6,
        REG_HI_FAULT      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0] lo_fault_level;
        logic [THR_W-1:0] lo_flag_set_level;
        logic [THR_W-1:0] normal_return_low;
        logic [THR_W-1:0] normal_enter_low;
        logic [THR_W-1:0] normal_return_high;
        logic [THR_W-1:0] normal_leave_high;
        logic [THR_W-1:0] hi_flag_set_level;
        logic [THR_W-1:0] hi_fault_level;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        lo_fault_level:     THR_W'(1148),
        lo_flag_set_level:  THR_W'(1259),
        normal_return_low:  THR_W'(1438),
        normal_enter_low:   THR_W'(1633),
        normal_return_high: THR_W'(2939),
        normal_leave_high:  THR_W'(3020),
        hi_flag_set_level:  THR_W'(3330),
        hi_fault_level:     THR_W'(3346)
    };

    typedef struct packed {
        t_band band;
        logic  under;
        logic  over;
    } t_state;

    typedef struct packed {
        t_band band;
        logic  under_flag;
        logic  over_flag;
        logic  sample_bad;
    } t_result;

endpackage

>>> src/supply_voltage_band_classifier_top.sv
// channel   valid         stall         payload
// input     i_in_valid    o_in_stall    i_sample
// output    o_out_valid   i_out_stall   o_band, o_under_flag, o_over_flag, o_sample_bad
// config    i_cfg_we      -             i_cfg_index, i_cfg_data
//
// One word per cycle while the output is not stalled.
// The sample register feeds one compare/select pass into the result register,
// which also updates the band and flag state.
// Synchronous active-low reset: band initial, flags clear, thresholds default.
// Output stall holds the result register; the input stalls only when both hold.
module supply_voltage_band_classifier_top import svbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BAND_W-1:0]    o_band,
    output logic                 o_under_flag,
    output logic                 o_over_flag,
    output logic                 o_sample_bad,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    t_result             r_result;
    t_state              r_state;
    t_state              n_state;
    t_result             n_result;
    logic                out_hold;
    logic                fire;
    logic                accept;

    assign out_hold   = r_out_valid && i_out_stall;
    assign fire       = r_in_valid && !out_hold;
    assign o_in_stall = r_in_valid && out_hold;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_LO_FAULT:      r_cfg.lo_fault_level     <= i_cfg_data;
                REG_LO_FLAG_SET:   r_cfg.lo_flag_set_level  <= i_cfg_data;
                REG_NORM_RET_LOW:  r_cfg.normal_return_low  <= i_cfg_data;
                REG_NORM_ENT_LOW:  r_cfg.normal_enter_low   <= i_cfg_data;
                REG_NORM_RET_HIGH: r_cfg.normal_return_high <= i_cfg_data;
                REG_NORM_LV_HIGH:  r_cfg.normal_leave_high  <= i_cfg_data;
                REG_HI_FLAG_SET:   r_cfg.hi_flag_set_level  <= i_cfg_data;
                REG_HI_FAULT:      r_cfg.hi_fault_level     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
    end

    svbc_classify u_classify (
        .i_sample (r_sample),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.band  <= BAND_INIT;
            r_state.under <= 1'b0;
            r_state.over  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!out_hold) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_band       = r_result.band;
    assign o_under_flag = r_result.under_flag;
    assign o_over_flag  = r_result.over_flag;
    assign o_sample_bad = r_result.sample_bad;

endmodule

>>> src/svbc_classify.sv
module svbc_classify import svbc_pkg::*; (
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    input  t_state              i_state,
    output t_state              o_state,
    output t_result             o_result
);

    logic [SAMPLE_W-1:0] lf, lfs, nrl, nel, nrh, nlh, hfs, hf;
    logic                bad;
    logic                up_norm, up_high, up_hf;
    t_band               up_band;
    t_band               nxt_band;
    logic                nxt_under, nxt_over;

    assign lf  = SAMPLE_W'(i_cfg.lo_fault_level);
    assign lfs = SAMPLE_W'(i_cfg.lo_flag_set_level);
    assign nrl = SAMPLE_W'(i_cfg.normal_return_low);
    assign nel = SAMPLE_W'(i_cfg.normal_enter_low);
    assign nrh = SAMPLE_W'(i_cfg.normal_return_high);
    assign nlh = SAMPLE_W'(i_cfg.normal_leave_high);
    assign hfs = SAMPLE_W'(i_cfg.hi_flag_set_level);
    assign hf  = SAMPLE_W'(i_cfg.hi_fault_level);

    assign bad = (i_sample == '0) || (i_sample > FULL_SCALE_S);

    // shared upward moves
    assign up_norm = (i_sample >= nel) && (i_sample <= nlh);
    assign up_high = (i_sample > nlh) && (i_sample <= hf);
    assign up_hf   = (i_sample > hf);

    always_comb begin
        if (up_norm) begin
            up_band = BAND_NORM;
        end else if (up_high) begin
            up_band = BAND_HIGH;
        end else if (up_hf) begin
            up_band = BAND_HF;
        end else begin
            up_band = i_state.band;
        end
    end

    always_comb begin
        unique case (i_state.band)
            BAND_INIT: begin
                if (i_sample < lf) begin
                    nxt_band = BAND_LF;
                end else if (i_sample < nel) begin
                    nxt_band = BAND_LOW;
                end else begin
                    nxt_band = up_band;
                end
            end
            BAND_LF: begin
                if ((i_sample >= LF_EXIT_S) && (i_sample < nel)) begin
                    nxt_band = BAND_LOW;
                end else begin
                    nxt_band = up_band;
                end
            end
            BAND_HF: begin
                if ((i_sample > nrh) && (i_sample <= hfs)) begin
                    nxt_band = BAND_HIGH;
                end else if ((i_sample >= nrl) && (i_sample <= nrh)) begin
                    nxt_band = BAND_NORM;
                end else if ((i_sample >= lf) && (i_sample < nrl)) begin
                    nxt_band = BAND_LOW;
                end else if (i_sample < lf) begin
                    nxt_band = BAND_LF;
                end else begin
                    nxt_band = BAND_HF;
                end
            end
            BAND_LOW: begin
                if (i_sample < lf) begin
                    nxt_band = BAND_LF;
                end else begin
                    nxt_band = up_band;
                end
            end
            BAND_NORM: begin
                if ((i_sample >= lf) && (i_sample < nrl)) begin
                    nxt_band = BAND_LOW;
                end else if (i_sample < lf) begin
                    nxt_band = BAND_LF;
                end else if (up_high) begin
                    nxt_band = BAND_HIGH;
                end else if (up_hf) begin
                    nxt_band = BAND_HF;
                end else begin
                    nxt_band = BAND_NORM;
                end
            end
            BAND_HIGH: begin
                if ((i_sample >= nrl) && (i_sample <= nrh)) begin
                    nxt_band = BAND_NORM;
                end else if ((i_sample >= lf) && (i_sample < nrl)) begin
                    nxt_band = BAND_LOW;
                end else if (i_sample < lf) begin
                    nxt_band = BAND_LF;
                end else if (up_hf) begin
                    nxt_band = BAND_HF;
                end else begin
                    nxt_band = BAND_HIGH;
                end
            end
            default: begin
                nxt_band = BAND_INIT;
            end
        endcase
    end

    // set test first, clear test wins
    always_comb begin
        nxt_under = i_state.under;
        if (i_sample < lfs) begin
            nxt_under = 1'b1;
        end
        if (i_sample >= nel) begin
            nxt_under = 1'b0;
        end
        nxt_over = i_state.over;
        if (i_sample > hfs) begin
            nxt_over = 1'b1;
        end
        if (i_sample <= nrh) begin
            nxt_over = 1'b0;
        end
    end

    always_comb begin
        if (bad) begin
            o_state             = i_state;
            o_result.band       = BAND_LF;
            o_result.under_flag = i_state.under;
            o_result.over_flag  = i_state.over;
            o_result.sample_bad = 1'b1;
        end else begin
            o_state.band        = nxt_band;
            o_state.under       = nxt_under;
            o_state.over        = nxt_over;
            o_result.band       = nxt_band;
            o_result.under_flag = nxt_under;
            o_result.over_flag  = nxt_over;
            o_result.sample_bad = 1'b0;
        end
    end

endmodule

>>> src/svbc_checker.sv
`include "supply_voltage_band_classifier_top_defines.svh"

module svbc_checker import svbc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [BAND_W-1:0]    o_band,
    input logic                 o_under_flag,
    input logic                 o_over_flag,
    input logic                 o_sample_bad
);

    logic [BAND_W+2:0] out_word;

    assign out_word = {o_band, o_under_flag, o_over_flag, o_sample_bad};

    // stalled output word holds
    `SVBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))

    // initial code never leaves the block
    `SVBC_ASSERT_NOW(a_band_range, i_clk, i_rst_n, o_out_valid, o_band <= BAND_HF)

    // bad sample reports low fault
    `SVBC_ASSERT_NOW(a_bad_lf, i_clk, i_rst_n, o_out_valid && o_sample_bad, o_band == BAND_LF)

    // input backs up only behind a held output
    `SVBC_ASSERT_NOW(a_in_stall, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule

bind supply_voltage_band_classifier_top svbc_checker u_svbc_checker (.*);
